/* hdl/mpef_pkg.sv */
`default_nettype none

package mpef_pkg;

  // Work codes carried by an input item.
  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_FLUSH = 2'd3
  } mpef_func_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_BLOCK = 2'd3
  } mpef_kind_e;

  // Packet framing phase.
  typedef enum logic [1:0] {
    PH_SYNC = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } mpef_phase_e;

  // Configuration register indexes.
  localparam logic CFG_DEVICE_OPEN = 1'b0;
  localparam logic CFG_SCAN_MODE   = 1'b1;

  localparam logic [7:0] SYNC_MASK   = 8'hF8;
  localparam logic [7:0] SYNC_VALUE  = 8'h80;
  localparam logic [7:0] BUTTON_MASK = 8'h07;

  localparam logic signed [15:0] ACC_MAX = 16'sh7FFF;
  localparam logic signed [15:0] ACC_MIN = -16'sh8000;

  typedef struct packed {
    mpef_func_e  func;
    logic [7:0]  rx_byte;
    logic [5:0]  want_count;
    logic        want_latest;
    logic        no_wait;
    logic [31:0] now_seconds;
  } mpef_in_t;

  typedef struct packed {
    mpef_kind_e         kind;
    logic               byte_taken;
    logic [2:0]         buttons;
    logic signed [15:0] x_move;
    logic signed [15:0] y_move;
    logic [31:0]        stamp;
    logic               last;
    logic [5:0]         returned_count;
  } mpef_out_t;

  // One ring entry.
  typedef struct packed {
    logic [2:0]         buttons;
    logic signed [15:0] x_move;
    logic signed [15:0] y_move;
    logic [31:0]        stamp;
  } mpef_event_t;

  typedef struct packed {
    logic load;
    logic byte_go;
    logic tick_go;
    logic flush_go;
    logic read_go;
    logic event_go;
  } mpef_cmd_t;

  typedef struct packed {
    mpef_func_e func;
    logic       fill_zero;
    logic       n_zero;
    logic       last_event;
    logic       slot_free;
  } mpef_status_t;

endpackage

`default_nettype wire

/* hdl/mpef_ctrl.sv */
`default_nettype none

module mpef_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mpef_pkg::mpef_status_t status_i,
  output mpef_pkg::mpef_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_STREAM = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status_i.func)
          mpef_pkg::FUNC_BYTE: begin
            if (status_i.slot_free) begin
              cmd_o.byte_go = 1'b1;
              state_d       = ST_IDLE;
            end
          end
          mpef_pkg::FUNC_TICK: begin
            cmd_o.tick_go = 1'b1;
            state_d       = ST_IDLE;
          end
          mpef_pkg::FUNC_FLUSH: begin
            cmd_o.flush_go = 1'b1;
            state_d        = ST_IDLE;
          end
          mpef_pkg::FUNC_READ: begin
            // A read that returns nothing needs the output slot for its
            // single result; a read with events streams them afterwards.
            if (status_i.fill_zero || status_i.n_zero) begin
              if (status_i.slot_free) begin
                cmd_o.read_go = 1'b1;
                state_d       = ST_IDLE;
              end
            end else begin
              cmd_o.read_go = 1'b1;
              state_d       = ST_STREAM;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_STREAM: begin
        if (status_i.slot_free) begin
          cmd_o.event_go = 1'b1;
          if (status_i.last_event) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/mpef_dp.sv */
`default_nettype none

module mpef_dp #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic                   cfg_data_i,
  input  mpef_pkg::mpef_in_t     in_data_i,
  input  logic                   out_ready_i,
  input  mpef_pkg::mpef_cmd_t    cmd_i,
  output mpef_pkg::mpef_status_t status_o,
  output logic                   out_valid_o,
  output mpef_pkg::mpef_out_t    out_data_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW = (FW > 6) ? FW : 6;

  // Configuration.
  logic open_q, scan_q;

  // Latched input item.
  mpef_pkg::mpef_in_t in_q;

  // Framer and scan state.
  mpef_pkg::mpef_phase_e phase_q, phase_d;
  logic [2:0]         hbtn_q, hbtn_d;
  logic [7:0]         hx_q, hx_d;
  logic [2:0]         cbtn_q, cbtn_d;
  logic signed [15:0] ax_q, ax_d, ay_q, ay_d;

  // Ring control.
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [5:0]    remain_q, remain_d, total_q, total_d;

  // Ring storage and its registered read port.
  mpef_pkg::mpef_event_t ring_mem [RING_DEPTH];
  mpef_pkg::mpef_event_t rd_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  mpef_pkg::mpef_out_t out_q, out_d;
  logic                out_load;
  logic                slot_free;

  logic                  push_en;
  mpef_pkg::mpef_event_t push_ev;

  logic [PW-1:0]      wp_next, rp_next;
  logic signed [15:0] dx, dy;
  logic signed [16:0] sum_x, sum_y;
  logic signed [15:0] sat_x, sat_y;
  logic [CW-1:0]      want_w, fill_w, n_w;
  logic [5:0]         n_cnt;
  logic [FW-1:0]      skip;
  logic [FW:0]        trim_sum;
  logic [PW-1:0]      rp_trim;
  logic               is_sync;
  logic [FW:0]        chk_sum;
  logic [PW-1:0]      chk_wp;

  assign slot_free = !out_valid_q || out_ready_i;

  assign wp_next = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == PW'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;

  assign dx = {{8{hx_q[7]}}, hx_q};
  assign dy = {{8{in_q.rx_byte[7]}}, in_q.rx_byte};

  assign sum_x = {ax_q[15], ax_q} + {dx[15], dx};
  assign sum_y = {ay_q[15], ay_q} + {dy[15], dy};

  // Clamp when the 17-bit sum leaves the 16-bit range.
  assign sat_x = (sum_x[16] != sum_x[15]) ? (sum_x[16] ? mpef_pkg::ACC_MIN : mpef_pkg::ACC_MAX)
                                          : sum_x[15:0];
  assign sat_y = (sum_y[16] != sum_y[15]) ? (sum_y[16] ? mpef_pkg::ACC_MIN : mpef_pkg::ACC_MAX)
                                          : sum_y[15:0];

  assign want_w = CW'(in_q.want_count);
  assign fill_w = CW'(fill_q);
  assign n_w    = (want_w < fill_w) ? want_w : fill_w;
  assign n_cnt  = n_w[5:0];

  // Taking the latest events skips the older ones ahead of the read pointer.
  assign skip     = fill_q - FW'(n_w);
  assign trim_sum = (FW+1)'(rp_q) + (FW+1)'(skip);
  assign rp_trim  = (trim_sum >= (FW+1)'(RING_DEPTH)) ? PW'(trim_sum - (FW+1)'(RING_DEPTH))
                                                      : PW'(trim_sum);

  assign is_sync = (in_q.rx_byte & mpef_pkg::SYNC_MASK) == mpef_pkg::SYNC_VALUE;

  always_comb begin
    phase_d  = phase_q;
    hbtn_d   = hbtn_q;
    hx_d     = hx_q;
    cbtn_d   = cbtn_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    fill_d   = fill_q;
    remain_d = remain_q;
    total_d  = total_q;
    out_load = 1'b0;
    out_d    = '0;
    push_en  = 1'b0;
    push_ev  = '0;

    if (cmd_i.byte_go) begin
      out_load   = 1'b1;
      out_d.kind = mpef_pkg::KIND_BYTE;
      out_d.last = 1'b1;
      unique case (phase_q)
        mpef_pkg::PH_X: begin
          hx_d             = in_q.rx_byte;
          phase_d          = mpef_pkg::PH_Y;
          out_d.byte_taken = 1'b1;
        end
        mpef_pkg::PH_Y: begin
          phase_d          = mpef_pkg::PH_SYNC;
          out_d.byte_taken = 1'b1;
          if (open_q) begin
            if (!scan_q) begin
              push_en        = 1'b1;
              push_ev.buttons = hbtn_q;
              push_ev.x_move = dx;
              push_ev.y_move = dy;
              push_ev.stamp  = in_q.now_seconds;
            end else begin
              ax_d = sat_x;
              ay_d = sat_y;
              if (hbtn_q != cbtn_q) begin
                push_en         = 1'b1;
                push_ev.buttons = hbtn_q;
                push_ev.stamp   = in_q.now_seconds;
              end
            end
          end
        end
        default: begin
          if (is_sync) begin
            hbtn_d           = 3'(in_q.rx_byte & mpef_pkg::BUTTON_MASK);
            phase_d          = mpef_pkg::PH_X;
            out_d.byte_taken = 1'b1;
          end else begin
            phase_d = mpef_pkg::PH_SYNC;
          end
        end
      endcase
    end

    if (cmd_i.tick_go && scan_q && ((ax_q != '0) || (ay_q != '0))) begin
      push_en         = 1'b1;
      push_ev.buttons = cbtn_q;
      push_ev.x_move  = ax_q;
      push_ev.y_move  = ay_q;
      push_ev.stamp   = in_q.now_seconds;
      ax_d            = '0;
      ay_d            = '0;
    end

    if (cmd_i.flush_go) begin
      wp_d   = '0;
      rp_d   = '0;
      fill_d = '0;
    end

    if (cmd_i.read_go) begin
      if (fill_q == '0) begin
        out_load   = 1'b1;
        out_d.kind = in_q.no_wait ? mpef_pkg::KIND_NONE : mpef_pkg::KIND_BLOCK;
        out_d.last = 1'b1;
      end else begin
        if (in_q.want_latest) begin
          rp_d   = rp_trim;
          fill_d = FW'(n_w);
        end
        if (n_cnt == '0) begin
          out_load   = 1'b1;
          out_d.kind = mpef_pkg::KIND_NONE;
          out_d.last = 1'b1;
        end else begin
          remain_d = n_cnt;
          total_d  = n_cnt;
        end
      end
    end

    if (cmd_i.event_go) begin
      out_load             = 1'b1;
      out_d.kind           = mpef_pkg::KIND_EVENT;
      out_d.buttons        = rd_q.buttons;
      out_d.x_move         = rd_q.x_move;
      out_d.y_move         = rd_q.y_move;
      out_d.stamp          = rd_q.stamp;
      out_d.last           = (remain_q == 6'd1);
      out_d.returned_count = total_q;
      rp_d                 = rp_next;
      fill_d               = fill_q - 1'b1;
      remain_d             = remain_q - 1'b1;
    end

    // A push into a full ring drops the oldest event.
    if (push_en) begin
      cbtn_d = push_ev.buttons;
      wp_d   = wp_next;
      if (fill_q == FW'(RING_DEPTH)) begin
        rp_d = rp_next;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      scan_q      <= 1'b0;
      phase_q     <= mpef_pkg::PH_SYNC;
      hbtn_q      <= '0;
      hx_q        <= '0;
      cbtn_q      <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      remain_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mpef_pkg::CFG_DEVICE_OPEN) begin
          open_q <= cfg_data_i;
        end
        if (cfg_idx_i == mpef_pkg::CFG_SCAN_MODE) begin
          scan_q <= cfg_data_i;
        end
      end
      phase_q     <= phase_d;
      hbtn_q      <= hbtn_d;
      hx_q        <= hx_d;
      cbtn_q      <= cbtn_d;
      ax_q        <= ax_d;
      ay_q        <= ay_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      remain_q    <= remain_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // The read port follows the next read pointer, so the oldest event is
  // always waiting in rd_q when streaming starts or continues.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      ring_mem[wp_q] <= push_ev;
    end
    rd_q <= ring_mem[rp_d];
  end

  assign status_o.func       = in_q.func;
  assign status_o.fill_zero  = (fill_q == '0);
  assign status_o.n_zero     = (in_q.want_count == '0);
  assign status_o.last_event = (remain_q == 6'd1);
  assign status_o.slot_free  = slot_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The write pointer always sits fill entries past the read pointer.
  assign chk_sum = (FW+1)'(rp_q) + (FW+1)'(fill_q);
  assign chk_wp  = (chk_sum >= (FW+1)'(RING_DEPTH)) ? PW'(chk_sum - (FW+1)'(RING_DEPTH))
                                                    : PW'(chk_sum);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(RING_DEPTH))
    else $error("ring fill count exceeds the ring depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_wp == wp_q)
    else $error("ring pointers disagree with the fill count");

  a_event_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.event_go |-> (remain_q != '0) && (fill_q != '0))
    else $error("event streamed with nothing left to read");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("output register overwritten before its transfer");

endmodule

`default_nettype wire

/* hdl/mouse_packet_event_fifo.sv */
// Byte, scan tick and flush items are accepted in the idle state and executed in the execute state.
// A byte verdict is loaded into the output register once the execute state finds the output slot free.
// A read streams its returned events one at a time from the ring
// memory's registered read port; output backpressure holds the stream.
// Reset is asynchronous and clears the framer, accumulators and ring pointers;
// the ring storage itself is not cleared and needs no clearing pass.
`default_nettype none

module mouse_packet_event_fifo #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mpef_pkg::mpef_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpef_pkg::mpef_out_t out_data_o
);

  mpef_pkg::mpef_cmd_t    cmd;
  mpef_pkg::mpef_status_t status;

  mpef_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpef_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* bench/mouse_packet_event_fifo_tb.sv */
`timescale 1ns / 1ps

module mouse_packet_event_fifo_tb;

  localparam int DEPTH        = 64;
  localparam int IDLE_PAUSE   = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 215;
  localparam int FULL_PACKETS = 70;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  logic                cfg_idx  = 1'b0;
  logic                cfg_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mpef_pkg::mpef_in_t  in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mpef_pkg::mpef_out_t out_data;

  mouse_packet_event_fifo #(
    .RING_DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Shadow copy of the framer, accumulators and event ring.
  mpef_pkg::mpef_phase_e phase    = mpef_pkg::PH_SYNC;
  logic [2:0]            held_btn = '0;
  logic [2:0]            cur_btn  = '0;
  logic [7:0]            held_x   = '0;
  int                    acc_x    = 0;
  int                    acc_y    = 0;
  mpef_pkg::mpef_event_t ring [DEPTH];
  int                    wr_ptr   = 0;
  int                    rd_ptr   = 0;
  int                    fill     = 0;
  logic                  dev_open = 1'b0;
  logic                  scan_on  = 1'b0;

  mpef_pkg::mpef_out_t awaited_results [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int cycles        = 0;
  int config_seg    = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mouse_packet_event_fifo_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int clamp16(int v);
    if (v > int'(mpef_pkg::ACC_MAX)) return int'(mpef_pkg::ACC_MAX);
    if (v < int'(mpef_pkg::ACC_MIN)) return int'(mpef_pkg::ACC_MIN);
    return v;
  endfunction

  function automatic void push_event(logic [2:0] btn, int x, int y, logic [31:0] now);
    cur_btn = btn;
    ring[wr_ptr] = '{btn, 16'(x), 16'(y), now};
    wr_ptr = (wr_ptr + 1) % DEPTH;
    // A full ring loses its oldest event.
    if (fill >= DEPTH) rd_ptr = (rd_ptr + 1) % DEPTH;
    else fill++;
  endfunction

  function automatic void mouse_decode(mpef_pkg::mpef_in_t it);
    mpef_pkg::mpef_out_t r;
    int n;
    r = '0;
    r.last = 1'b1;
    case (it.func)
      mpef_pkg::FUNC_BYTE: begin
        r.kind = mpef_pkg::KIND_BYTE;
        r.byte_taken = 1'b1;
        case (phase)
          mpef_pkg::PH_X: begin
            held_x = it.rx_byte;
            phase = mpef_pkg::PH_Y;
          end
          mpef_pkg::PH_Y: begin
            phase = mpef_pkg::PH_SYNC;
            if (dev_open) begin
              if (!scan_on) begin
                push_event(held_btn, int'($signed(held_x)), int'($signed(it.rx_byte)),
                           it.now_seconds);
              end else begin
                acc_x = clamp16(acc_x + int'($signed(held_x)));
                acc_y = clamp16(acc_y + int'($signed(it.rx_byte)));
                if (held_btn != cur_btn) push_event(held_btn, 0, 0, it.now_seconds);
              end
            end
          end
          default: begin
            if ((it.rx_byte & mpef_pkg::SYNC_MASK) != mpef_pkg::SYNC_VALUE) begin
              phase = mpef_pkg::PH_SYNC;
              r.byte_taken = 1'b0;
            end else begin
              held_btn = it.rx_byte[2:0];
              phase = mpef_pkg::PH_X;
            end
          end
        endcase
        awaited_results.push_back(r);
      end
      mpef_pkg::FUNC_TICK: begin
        if (scan_on && (acc_x != 0 || acc_y != 0)) begin
          push_event(cur_btn, acc_x, acc_y, it.now_seconds);
          acc_x = 0;
          acc_y = 0;
        end
      end
      mpef_pkg::FUNC_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
        fill = 0;
      end
      default: begin
        if (fill == 0) begin
          r.kind = it.no_wait ? mpef_pkg::KIND_NONE : mpef_pkg::KIND_BLOCK;
          awaited_results.push_back(r);
        end else begin
          n = (int'(it.want_count) < fill) ? int'(it.want_count) : fill;
          // Taking the newest events throws the older ones away.
          if (it.want_latest) begin
            rd_ptr = (rd_ptr + fill - n) % DEPTH;
            fill = n;
          end
          if (n == 0) begin
            r.kind = mpef_pkg::KIND_NONE;
            awaited_results.push_back(r);
          end else begin
            for (int i = 0; i < n; i++) begin
              r = '0;
              r.kind = mpef_pkg::KIND_EVENT;
              r.buttons = ring[rd_ptr].buttons;
              r.x_move = ring[rd_ptr].x_move;
              r.y_move = ring[rd_ptr].y_move;
              r.stamp = ring[rd_ptr].stamp;
              r.last = (i == n - 1);
              r.returned_count = 6'(n);
              awaited_results.push_back(r);
              rd_ptr = (rd_ptr + 1) % DEPTH;
              fill--;
            end
          end
        end
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input mpef_pkg::mpef_out_t want,
                               input mpef_pkg::mpef_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d", what, cycles);
      $display("  expected kind %0d taken %0d btn %0d x %0d y %0d stamp %h last %0d count %0d",
               want.kind, want.byte_taken, want.buttons, want.x_move, want.y_move,
               want.stamp, want.last, want.returned_count);
      $display("  got      kind %0d taken %0d btn %0d x %0d y %0d stamp %h last %0d count %0d",
               got.kind, got.byte_taken, got.buttons, got.x_move, got.y_move,
               got.stamp, got.last, got.returned_count);
    end
  endtask

  always @(posedge clk_i) begin
    mpef_pkg::mpef_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result", '0, out_data);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.kind !== want.kind || out_data.byte_taken !== want.byte_taken ||
            out_data.buttons !== want.buttons || out_data.x_move !== want.x_move ||
            out_data.y_move !== want.y_move || out_data.stamp !== want.stamp ||
            out_data.last !== want.last ||
            out_data.returned_count !== want.returned_count)
          note_mismatch("result mismatch", want, out_data);
      end
    end
  end

  function automatic mpef_pkg::mpef_in_t any_item();
    logic [63:0] raw;
    mpef_pkg::mpef_in_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(mpef_pkg::mpef_in_t)-1:0];
    return it;
  endfunction

  function automatic mpef_pkg::mpef_in_t byte_item(logic [7:0] b);
    mpef_pkg::mpef_in_t it;
    it = any_item();
    it.func = mpef_pkg::FUNC_BYTE;
    it.rx_byte = b;
    return it;
  endfunction

  function automatic mpef_pkg::mpef_in_t op_item(mpef_pkg::mpef_func_e f);
    mpef_pkg::mpef_in_t it;
    it = any_item();
    it.func = f;
    return it;
  endfunction

  function automatic mpef_pkg::mpef_in_t read_item(logic [5:0] want, logic latest,
                                                   logic nowait);
    mpef_pkg::mpef_in_t it;
    it = op_item(mpef_pkg::FUNC_READ);
    it.want_count = want;
    it.want_latest = latest;
    it.no_wait = nowait;
    return it;
  endfunction

  // Called at a clock edge; returns at the edge where the transfer happens.
  task automatic send_item(input mpef_pkg::mpef_in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    mouse_decode(it);
  endtask

  task automatic send_packet(input logic [2:0] btn, input logic [7:0] x, input logic [7:0] y);
    send_item(byte_item(mpef_pkg::SYNC_VALUE | {5'b0, btn}));
    send_item(byte_item(x));
    send_item(byte_item(y));
  endtask

  // Ticks and flushes give no result, so a pause follows the last one that does.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic open_dev, input logic scan);
    cfg_we <= 1'b1;
    cfg_idx <= mpef_pkg::CFG_DEVICE_OPEN;
    cfg_data <= open_dev;
    @(posedge clk_i);
    dev_open = open_dev;
    cfg_idx <= mpef_pkg::CFG_SCAN_MODE;
    cfg_data <= scan;
    @(posedge clk_i);
    scan_on = scan;
    cfg_we <= 1'b0;
  endtask

  task automatic test_closed_device();
    set_config(1'b0, 1'b0);
    send_item(byte_item(8'h00));
    send_item(byte_item(8'hFF));
    send_item(byte_item(8'h88));
    // The packet is framed but dropped while the device is closed.
    send_packet(3'd7, 8'h7F, 8'h80);
    send_item(read_item(6'd1, 1'b0, 1'b1));
    send_item(read_item(6'd1, 1'b0, 1'b0));
    send_item(op_item(mpef_pkg::FUNC_TICK));
    wait_idle();
  endtask

  task automatic test_direct_mode();
    mpef_pkg::mpef_in_t it;
    set_config(1'b1, 1'b0);
    send_packet(3'd0, 8'h80, 8'h7F);
    it = byte_item(8'h87);
    send_item(it);
    send_item(byte_item(8'hFF));
    it = byte_item(8'h00);
    it.now_seconds = 32'hFFFF_FFFF;
    send_item(it);
    send_item(read_item(6'd0, 1'b0, 1'b1));
    send_item(read_item(6'd63, 1'b0, 1'b0));
    send_packet(3'd1, 8'h01, 8'hFE);
    send_packet(3'd2, 8'h40, 8'hC0);
    send_item(read_item(6'd1, 1'b1, 1'b0));
    send_item(read_item(6'd3, 1'b0, 1'b0));
    send_packet(3'd4, 8'h11, 8'h22);
    send_item(read_item(6'd0, 1'b1, 1'b1));
    send_packet(3'd6, 8'h33, 8'h44);
    send_item(op_item(mpef_pkg::FUNC_FLUSH));
    send_item(read_item(6'd2, 1'b0, 1'b1));
    wait_idle();
  endtask

  task automatic test_scan_mode();
    set_config(1'b1, 1'b1);
    send_packet(3'd5, 8'h10, 8'hF0);
    send_packet(3'd5, 8'h7F, 8'h80);
    send_item(op_item(mpef_pkg::FUNC_TICK));
    send_item(op_item(mpef_pkg::FUNC_TICK));
    send_item(read_item(6'd63, 1'b0, 1'b0));
    wait_idle();
  endtask

  // More packets than the ring holds, so the oldest events are dropped.
  task automatic test_ring_overflow();
    set_config(1'b1, 1'b0);
    for (int i = 0; i < FULL_PACKETS; i++)
      send_packet(3'($urandom), 8'($urandom), 8'($urandom));
    send_item(read_item(6'd63, 1'b0, 1'b1));
    send_item(read_item(6'd63, 1'b0, 1'b1));
    wait_idle();
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct, input int count);
    int done;
    int seg_left;
    int pick;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    done = 0;
    seg_left = 0;
    while (done < count) begin
      if (seg_left <= 0) begin
        wait_idle();
        set_config((config_seg % 3) != 2, (config_seg % 2) == 1);
        config_seg++;
        seg_left = 40;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_packet(3'($urandom), 8'($urandom), 8'($urandom));
        done += 3;
        seg_left -= 3;
      end else if (pick < 65) begin
        send_item(byte_item(8'($urandom)));
        done++;
        seg_left--;
      end else if (pick < 70) begin
        // Cut-off packet; the next byte lands in the X or Y slot.
        send_item(byte_item(mpef_pkg::SYNC_VALUE | {5'b0, 3'($urandom)}));
        if ($urandom_range(1)) send_item(byte_item(8'($urandom)));
        done += 2;
        seg_left -= 2;
      end else if (pick < 88) begin
        send_item(read_item(($urandom_range(1) ? 6'($urandom_range(4)) : 6'($urandom)),
                            ($urandom_range(99) < 30), 1'($urandom)));
        done++;
        seg_left--;
      end else if (pick < 94) begin
        send_item(op_item(mpef_pkg::FUNC_TICK));
        done++;
        seg_left--;
      end else if (pick < 97) begin
        send_item(op_item(mpef_pkg::FUNC_FLUSH));
        done++;
        seg_left--;
      end else begin
        send_item(any_item());
        done++;
        seg_left--;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 22;
    recv_idle_pct = 71;
    test_closed_device();
    test_direct_mode();
    test_scan_mode();
    test_random(22, 71, RANDOM_ITEMS / 3);
    test_random(71, 22, RANDOM_ITEMS / 3);
    test_ring_overflow();
    test_random(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    wait_idle();
    if (mismatches == 0) begin
      $display("mouse_packet_event_fifo_tb OK");
    end else begin
      $display("mouse_packet_event_fifo_tb NOT OK");
    end
    $finish;
  end

endmodule
